// File: src/wism_pkg.sv
// Shared types and constants for the weighted increasing subsequence block.
// No dependencies; compile first.
package wism_pkg;

  localparam int unsigned RANK_W   = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned WEIGHT_W = 31;
  localparam int unsigned SUM_W    = 48;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic                start_sequence;
    logic [RANK_W-1:0]   key_rank;
    logic [COUNT_W-1:0]  smaller_count;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] ending_sum;
    logic [SUM_W-1:0] best_sum;
  } out_item_t;

endpackage

// File: src/wism_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used by weighted_increasing_subsequence_max for its request and result channels.
interface wism_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/wism_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wism_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/weighted_increasing_subsequence_max.sv
// Max-weight increasing subsequence over a prefix-max Fenwick tree held in one RAM.
// A request reads the query nodes, one per set bit of min(count, CAPACITY), adds its weight,
// then raises the Fenwick nodes from rank+1 up to CAPACITY and waits for the output register.
// One request at a time; the RAM's single read and write port walk the tree levels.
// Reset and a start flag run a clearing pass over all CAPACITY nodes with the input not ready.
// Depends on wism_pkg, wism_stream_if and wism_ram.
module weighted_increasing_subsequence_max #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wism_stream_if.sink   in_i,
  wism_stream_if.source out_o
);

  import wism_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CapIdx  = CW'(CAPACITY);
  localparam logic [AW-1:0] LastAdr = AW'(CAPACITY - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StClear  = 3'd1;
  localparam logic [2:0] StQuery  = 3'd2;
  localparam logic [2:0] StAdd    = 3'd3;
  localparam logic [2:0] StUpdate = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic             after_clear_q, after_clear_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] best_q, best_d;
  in_item_t         item_q, item_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  logic [CW-1:0]    idx_low;
  logic [CW-1:0]    idx_dec;
  logic [CW-1:0]    rank_next;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             in_ready;

  // Clamp the smaller-key count to the tree size
  function automatic logic [CW-1:0] clip_count(input logic [COUNT_W-1:0] count);
    logic [CW-1:0] ext;
    ext = CW'(count);
    return (ext > CapIdx) ? CapIdx : ext;
  endfunction

  // Shared index arithmetic for both tree walks
  assign idx_low   = idx_q & (~idx_q + CW'(1));
  assign idx_dec   = idx_q - CW'(1);
  assign rank_next = CW'(item_q.key_rank) + CW'(1);

  // Saturating add of the prefix max and the weight
  assign sum_wide = {1'b0, acc_q} + (SUM_W + 1)'(item_q.weight);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  // Sequencer
  always_comb begin
    state_d       = state_q;
    after_clear_d = after_clear_q;
    clr_d         = clr_q;
    idx_d         = idx_q;
    rd_pend_d     = rd_pend_q;
    pend_addr_d   = pend_addr_q;
    acc_d         = acc_q;
    sum_d         = sum_q;
    best_d        = best_q;
    item_d        = item_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    ram_we        = 1'b0;
    ram_waddr     = pend_addr_q;
    ram_wdata     = sum_q;
    ram_raddr     = idx_dec[AW-1:0];
    in_ready      = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          item_d    = in_i.data;
          idx_d     = clip_count(in_i.data.smaller_count);
          acc_d     = '0;
          rd_pend_d = 1'b0;
          if (in_i.data.start_sequence) begin
            clr_d         = '0;
            best_d        = '0;
            after_clear_d = 1'b1;
            state_d       = StClear;
          end else begin
            state_d = StQuery;
          end
        end
      end
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAdr) begin
          if (after_clear_q) begin
            after_clear_d = 1'b0;
            idx_d         = clip_count(item_q.smaller_count);
            acc_d         = '0;
            rd_pend_d     = 1'b0;
            state_d       = StQuery;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StQuery: begin
        // Fold the node read last cycle, issue the next one
        if (rd_pend_q && (ram_rdata > acc_q)) begin
          acc_d = ram_rdata;
        end
        if (idx_q != '0) begin
          rd_pend_d = 1'b1;
          idx_d     = idx_q - idx_low;
        end else begin
          rd_pend_d = 1'b0;
          state_d   = StAdd;
        end
      end
      StAdd: begin
        sum_d = sum_sat;
        if (sum_sat > best_q) begin
          best_d = sum_sat;
        end
        idx_d     = rank_next;
        rd_pend_d = 1'b0;
        state_d   = StUpdate;
      end
      StUpdate: begin
        // Raise the node read last cycle, issue the next one
        if (rd_pend_q && (ram_rdata < sum_q)) begin
          ram_we = 1'b1;
        end
        if (idx_q <= CapIdx) begin
          rd_pend_d   = 1'b1;
          pend_addr_d = idx_dec[AW-1:0];
          idx_d       = idx_q + idx_low;
        end else begin
          rd_pend_d = 1'b0;
          state_d   = StOut;
        end
      end
      StOut: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d         = 1'b1;
          out_data_d.ending_sum = sum_q;
          out_data_d.best_sum   = best_q;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      after_clear_q <= 1'b0;
      clr_q         <= '0;
      rd_pend_q     <= 1'b0;
      best_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      after_clear_q <= after_clear_d;
      clr_q         <= clr_d;
      rd_pend_q     <= rd_pend_d;
      best_q        <= best_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    acc_q       <= acc_d;
    sum_q       <= sum_d;
    item_q      <= item_d;
    out_data_q  <= out_data_d;
  end

  // Fenwick tree storage, node i at address i-1
  wism_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CAPACITY)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: src/wism_checker.sv
// Port-level checks for weighted_increasing_subsequence_max, attached by bind.
// Depends on wism_pkg and the top level's stream interface ports.
module wism_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input wism_pkg::out_item_t out_data_i
);

  import wism_pkg::*;

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed or dropped");

  // One request at a time: not ready right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted request");

  // A result never rises right after an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after a request");

  // The running best covers the sum it was updated with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.best_sum >= out_data_i.ending_sum))
    else $error("best sum below ending sum");

endmodule

bind weighted_increasing_subsequence_max wism_checker u_wism_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
